FILE: src/uwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uwt_pkg
// Shared constants, types and helpers for the identifier whitelist table.
// ----------------------------------------------------------------------------
package uwt_pkg;

    // Table size defaults and field widths.
    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int FUNC_W   = 2;
    localparam int ID_W     = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_CHECK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd4;

    // Value that an erased slot holds.
    localparam logic [ID_W-1:0] ID_ERASED = 32'hFFFF_FFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // latch the request and clear the scan state
        logic compare;  // evaluate the entry read at the current index
        logic advance;  // step the scan index
        logic commit;   // update the table and register the result word
    } uwt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;     // scan index sits on the final entry
    } uwt_stat_t;

    // A slot is empty when every byte is 0x00 or 0xFF.
    function automatic logic slot_is_empty(input logic [ID_W-1:0] v);
        logic empty;
        empty = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (v[8*k +: 8] != 8'h00 && v[8*k +: 8] != 8'hFF) begin
                empty = 1'b0;
            end
        end
        return empty;
    endfunction

endpackage

FILE: src/uwt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uwt_ctrl
// Sequencer that walks the table entry by entry (read state, then compare state) and commits.
// ----------------------------------------------------------------------------
module uwt_ctrl
    import uwt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  uwt_stat_t stat,
    output uwt_cmd_t  cmd,
    output logic      busy
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_CMP    = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                if (stat.last)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: src/uwt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uwt_datapath
// Identifier store, scan index, match tracking and result registers.
// ----------------------------------------------------------------------------
module uwt_datapath
    import uwt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  uwt_cmd_t            cmd,
    input  logic [FUNC_W-1:0]   func,
    input  logic [ID_W-1:0]     card_id,
    output uwt_stat_t           stat,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   slot
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    // Storage: data array plus a valid bit per entry; invalid reads as erased.
    logic [ID_W-1:0]          id_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [ID_W-1:0]          rd_data_reg;
    logic                     rd_valid_reg;

    // Request and scan state.
    logic [FUNC_W-1:0] func_reg;
    logic [ID_W-1:0]   id_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic              free_reg;
    logic [IDX_W-1:0]  free_idx_reg;

    // Result word.
    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [STATUS_W-1:0] status_next;
    logic [IDX_W-1:0]    slot_idx_next;
    logic                slot_used_next;
    logic [IDX_W+SLOT_W-1:0] slot_ext;

    logic [ID_W-1:0] entry;
    logic            wr_add;
    logic            wr_del;

    assign entry     = rd_valid_reg ? rd_data_reg : ID_ERASED;
    assign stat.last = (idx_reg == IDX_LAST);

    // Result decode from the scan outcome.
    always_comb
    begin
        status_next    = ST_NOT_FOUND;
        slot_idx_next  = '0;
        slot_used_next = 1'b0;
        wr_add         = 1'b0;
        wr_del         = 1'b0;
        unique case (func_reg)
            FUNC_CHECK:
            begin
                if (hit_reg)
                begin
                    status_next    = ST_FOUND;
                    slot_idx_next  = hit_idx_reg;
                    slot_used_next = 1'b1;
                end
            end
            FUNC_ADD:
            begin
                if (hit_reg)
                begin
                    status_next    = ST_FOUND;
                    slot_idx_next  = hit_idx_reg;
                    slot_used_next = 1'b1;
                end
                else if (free_reg)
                begin
                    status_next    = ST_ADDED;
                    slot_idx_next  = free_idx_reg;
                    slot_used_next = 1'b1;
                    wr_add         = 1'b1;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            FUNC_DELETE:
            begin
                if (hit_reg)
                begin
                    status_next    = ST_DELETED;
                    slot_idx_next  = hit_idx_reg;
                    slot_used_next = 1'b1;
                    wr_del         = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_NOT_FOUND;
            end
        endcase
    end

    // Slot field carries the low bits of the index, zero when none is used.
    assign slot_ext = {{SLOT_W{1'b0}}, (slot_used_next ? slot_idx_next : {IDX_W{1'b0}})};

    // Data array: written on commit of an add, read at the scan index.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_add)
        begin
            id_mem[free_idx_reg] <= id_reg;
        end
        rd_data_reg <= id_mem[idx_reg];
    end

    // Valid bits clear at reset so every entry starts erased.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[idx_reg];
            if (cmd.commit && wr_add)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (cmd.commit && wr_del)
            begin
                valid_reg[hit_idx_reg] <= 1'b0;
            end
        end
    end

    // Request capture and scan tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            func_reg <= FUNC_CHECK;
        end
        else if (cmd.load)
        begin
            idx_reg  <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            func_reg <= func;
        end
        else
        begin
            if (cmd.compare)
            begin
                if (!hit_reg && entry == id_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (!free_reg && slot_is_empty(entry))
                begin
                    free_reg <= 1'b1;
                end
            end
            if (cmd.advance)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Payload registers for the request and the found indexes.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg <= card_id;
        end
        if (cmd.compare && !hit_reg && entry == id_reg)
        begin
            hit_idx_reg <= idx_reg;
        end
        if (cmd.compare && !free_reg && slot_is_empty(entry))
        begin
            free_idx_reg <= idx_reg;
        end
        if (cmd.commit)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_ext[SLOT_W-1:0];
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit;
        end
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign slot   = slot_reg;

endmodule

FILE: src/uid_whitelist_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uid_whitelist_table_top
// Card identifier whitelist with check, add and delete requests.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (func, card_id) is taken at a rising edge where start is
//   high and busy is low. busy stays high while the request is worked on.
//   The block scans every slot from 0 upward, with a read state then a compare
//   state per slot, tracking the lowest matching slot and the lowest empty
//   slot in a single pass. A final commit state then updates the store.
//   The result word (status, slot) is valid while done is high, which is
//   for exactly one cycle; busy is already low in that cycle, so the next
//   request may be taken at the same edge that takes the result.
//   The store has a single read port and is scanned one slot at a time;
//   one request is in flight at a time.
//   The receiver cannot stall; it must take the result in the done cycle.
//   Reset clears every valid bit, so all slots read as erased (all ones)
//   right away, with no clearing pass.
// ----------------------------------------------------------------------------
module uid_whitelist_table_top
    import uwt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   func,
    input  logic [ID_W-1:0]     card_id,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   slot
);

    uwt_cmd_t  cmd;
    uwt_stat_t stat;

    // Sequencer.
    uwt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Store and scan datapath.
    uwt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .func    (func),
        .card_id (card_id),
        .stat    (stat),
        .done    (done),
        .status  (status),
        .slot    (slot)
    );

    // A result is only shown once the sequencer has gone back to idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while sequencer busy");

    // An accepted request keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // Outcomes that use no slot report slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_NOT_FOUND || status == ST_FULL)) |-> (slot == '0))
        else $error("unused slot field is not zero");

    // No strobe unless busy was high just before it, as in the commit state.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result strobe without preceding work");

endmodule
